// ===== hdl/usd_pkg.sv =====
// Shared types and constants of the UTF-8 stream decoder.
package usd_pkg;

  localparam int unsigned CP_W = 21;

  localparam logic [CP_W-1:0] REPLACEMENT   = 21'h00FFFD;
  localparam logic [CP_W-1:0] MAX_SCALAR    = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO       = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI       = 21'h00DFFF;
  localparam logic [CP_W-1:0] MIN_TWO_BYTE  = 21'h000080;
  localparam logic [CP_W-1:0] MIN_THREE_BYTE = 21'h000800;
  localparam logic [CP_W-1:0] MIN_FOUR_BYTE = 21'h010000;

  localparam logic [2:0] LEN_NONE  = 3'd0;
  localparam logic [2:0] LEN_TWO   = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR  = 3'd4;

  // Results caused by one byte: rep_count replacements, then an optional good value.
  typedef struct packed {
    logic [2:0]      rep_count;
    logic            has_good;
    logic [CP_W-1:0] code_point;
  } usd_desc_t;

endpackage

// ===== hdl/usd_front.sv =====
// Front end: sequence tracking and classification of each input byte.
module usd_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         text_byte,
  input  logic               end_of_text,
  output logic               push,
  output usd_pkg::usd_desc_t desc
);

  logic [2:0]  exp_len;
  logic [2:0]  exp_len_next;
  logic [1:0]  held;
  logic [1:0]  held_next;
  logic [20:0] partial;
  logic [20:0] partial_next;

  logic        pending;
  logic        is_cont;
  logic        lead_ascii;
  logic [2:0]  lead_len;
  logic [20:0] lead_val;
  logic [20:0] cont_val;
  logic [2:0]  held_inc;
  logic        well_formed;

  assign pending  = exp_len != usd_pkg::LEN_NONE;
  assign is_cont  = text_byte[7:6] == 2'b10;
  assign cont_val = {partial[14:0], text_byte[5:0]};
  assign held_inc = {1'b0, held} + 3'd1;

  always_comb begin
    lead_ascii = 1'b0;
    lead_len   = usd_pkg::LEN_NONE;
    lead_val   = 21'd0;
    if (text_byte[7] == 1'b0) begin
      lead_ascii = 1'b1;
      lead_val   = {13'd0, text_byte};
    end else if (text_byte[7:5] == 3'b110) begin
      lead_len = usd_pkg::LEN_TWO;
      lead_val = {16'd0, text_byte[4:0]};
    end else if (text_byte[7:4] == 4'b1110) begin
      lead_len = usd_pkg::LEN_THREE;
      lead_val = {17'd0, text_byte[3:0]};
    end else if (text_byte[7:3] == 5'b11110) begin
      lead_len = usd_pkg::LEN_FOUR;
      lead_val = {18'd0, text_byte[2:0]};
    end
  end

  always_comb begin
    well_formed = 1'b1;
    if (exp_len == usd_pkg::LEN_TWO && cont_val < usd_pkg::MIN_TWO_BYTE) begin
      well_formed = 1'b0;
    end
    if (exp_len == usd_pkg::LEN_THREE && cont_val < usd_pkg::MIN_THREE_BYTE) begin
      well_formed = 1'b0;
    end
    if (exp_len == usd_pkg::LEN_FOUR && cont_val < usd_pkg::MIN_FOUR_BYTE) begin
      well_formed = 1'b0;
    end
    if (cont_val > usd_pkg::MAX_SCALAR) begin
      well_formed = 1'b0;
    end
    if (cont_val >= usd_pkg::SURR_LO && cont_val <= usd_pkg::SURR_HI) begin
      well_formed = 1'b0;
    end
  end

  always_comb begin
    desc         = '0;
    exp_len_next = exp_len;
    held_next    = held;
    partial_next = partial;
    if (pending && is_cont) begin
      if (held_inc == exp_len) begin
        if (well_formed) begin
          desc.has_good   = 1'b1;
          desc.code_point = cont_val;
        end else begin
          desc.rep_count = exp_len;
        end
        exp_len_next = usd_pkg::LEN_NONE;
        held_next    = 2'd0;
        partial_next = 21'd0;
      end else if (end_of_text) begin
        desc.rep_count = held_inc;
        exp_len_next   = usd_pkg::LEN_NONE;
        held_next      = 2'd0;
        partial_next   = 21'd0;
      end else begin
        held_next    = held_inc[1:0];
        partial_next = cont_val;
      end
    end else begin
      desc.rep_count = pending ? {1'b0, held} : 3'd0;
      exp_len_next   = usd_pkg::LEN_NONE;
      held_next      = 2'd0;
      partial_next   = 21'd0;
      if (lead_ascii) begin
        desc.has_good   = 1'b1;
        desc.code_point = lead_val;
      end else if (lead_len != usd_pkg::LEN_NONE) begin
        if (end_of_text) begin
          desc.rep_count = desc.rep_count + 3'd1;
        end else begin
          exp_len_next = lead_len;
          held_next    = 2'd1;
          partial_next = lead_val;
        end
      end else begin
        desc.rep_count = desc.rep_count + 3'd1;
      end
    end
  end

  assign push = accept && (desc.has_good || desc.rep_count != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_len <= usd_pkg::LEN_NONE;
      held    <= 2'd0;
      partial <= 21'd0;
    end else if (accept) begin
      exp_len <= exp_len_next;
      held    <= held_next;
      partial <= partial_next;
    end
  end

endmodule

// ===== hdl/usd_queue.sv =====
// Short queue of per-byte result descriptors between front and back end.
module usd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  usd_pkg::usd_desc_t push_desc,
  output logic               not_full,
  input  logic               pop,
  output logic               not_empty,
  output usd_pkg::usd_desc_t head
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  usd_pkg::usd_desc_t store [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign not_full  = count != CW'(DEPTH);
  assign not_empty = count != '0;
  assign head      = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_desc;
    end
  end

endmodule

// ===== hdl/usd_back.sv =====
// Back end: expands each descriptor into result beats behind an output register.
module usd_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  usd_pkg::usd_desc_t head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [20:0]        code_point,
  output logic               replaced,
  output logic               last_of_run
);

  logic [1:0] idx;
  logic [2:0] total;
  logic       load;
  logic       is_last;
  logic       is_rep;

  assign total   = head.rep_count + {2'd0, head.has_good};
  assign load    = head_valid && (!out_valid || out_ready);
  assign is_last = ({1'b0, idx} + 3'd1) == total;
  assign is_rep  = {1'b0, idx} < head.rep_count;
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= is_last ? 2'd0 : idx + 2'd1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_point  <= is_rep ? usd_pkg::REPLACEMENT : head.code_point;
      replaced    <= is_rep;
      last_of_run <= is_last;
    end
  end

endmodule

// ===== hdl/utf8_stream_decoder_top.sv =====
// Top level of the UTF-8 stream decoder.
//
// Input stream: one UTF-8 byte a beat on s_tdata[7:0]; s_tlast marks the
// final byte of the text, and any sequence still open is flushed as U+FFFD.
// Output stream: one code point a beat on m_tdata[20:0]; m_tuser is set on a
// replacement for malformed input, m_tlast on the final beat caused by a byte.
// A byte gives zero to four beats; one that only opens or extends a sequence
// gives none.
// The front end takes one byte every cycle while the descriptor queue has room
// and classifies it in that cycle. The back end sends one beat a cycle from the
// head of the queue while the queue holds a descriptor and m_tready is not low
// on a held beat; a byte that gives n beats holds the back end until all n are
// sent. When the queue is empty, the first beat of a byte passes through the
// queue store and then the output register before m_tvalid rises.
// When m_tready is low the output register holds its beat, the queue fills up
// to QUEUE_DEPTH descriptors, and then s_tready drops.
// Reset (rst, synchronous) empties the queue and output register and drops any
// open sequence.
module utf8_stream_decoder_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_byte
  input  logic        s_tlast,   // end_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
  output logic        m_tuser,   // replaced
  output logic        m_tlast    // last_of_run
);

  usd_pkg::usd_desc_t push_desc;
  usd_pkg::usd_desc_t head;
  logic               push;
  logic               pop;
  logic               head_valid;
  logic               accept;
  logic [20:0]        code_point;

  assign accept  = s_tvalid && s_tready;
  assign m_tdata = {3'd0, code_point};

  usd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .text_byte   (s_tdata),
    .end_of_text (s_tlast),
    .push        (push),
    .desc        (push_desc)
  );

  usd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .not_full  (s_tready),
    .pop       (pop),
    .not_empty (head_valid),
    .head      (head)
  );

  usd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .code_point  (code_point),
    .replaced    (m_tuser),
    .last_of_run (m_tlast)
  );

endmodule
